### rtl/core/sspq_pkg.sv
// sspq_pkg: shared types and codes of the stable sorted priority queue
// command and status codes, the item word passed from front to back
// no dependencies
package sspq_pkg;

  // fixed field widths of the ports
  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 8;
  localparam int COUNT_W = 5;

  // command codes on the input channel
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  // status codes on the result channel
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY_DEL = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY_RD  = 3'd4
  } status_t;

  // classified command word held in the queue between front and back
  typedef struct packed {
    cmd_t                 op;
    logic [VALUE_W-1:0]   value;
    logic [PRIO_W-1:0]    prio;
  } item_t;

endpackage

### rtl/core/sspq_front.sv
// sspq_front: command intake, decodes the command and masks the priority
// depends on sspq_pkg; feeds sspq_queue
module sspq_front import sspq_pkg::*; #(
  parameter int PW = 8
) (
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic [VALUE_W-1:0] in_item_value,
  input  logic [PRIO_W-1:0]  in_item_priority,
  input  logic               q_full,
  output logic               push,
  output item_t              push_item
);

  localparam logic [PRIO_W-1:0] PRIO_MASK = PRIO_W'({PW{1'b1}});

  logic accept;

  // a word is taken whenever the queue has room
  assign busy   = q_full;
  assign accept = start & ~q_full;

  // decode: unused command codes are dropped here
  always_comb begin
    push_item.op    = CMD_INSERT;
    push_item.value = in_item_value;
    push_item.prio  = in_item_priority & PRIO_MASK;
    push            = 1'b0;
    unique case (in_command)
      CMD_INSERT: begin
        push_item.op = CMD_INSERT;
        push         = accept;
      end
      CMD_DELETE: begin
        push_item.op = CMD_DELETE;
        push         = accept;
      end
      CMD_READ: begin
        push_item.op = CMD_READ;
        push         = accept;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

endmodule

### rtl/core/sspq_queue.sv
// sspq_queue: two-word queue decoupling command intake from execution
// depends on sspq_pkg
module sspq_queue import sspq_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  output logic  valid,
  input  logic  pop,
  output item_t head
);

  logic [1:0] cnt_r;
  item_t      e0_r;
  item_t      e1_r;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = e0_r;

  // shift-style queue: head always sits in e0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: begin
          if (cnt_r == 2'd0) begin
            e0_r <= push_item;
          end else begin
            e1_r <= push_item;
          end
          cnt_r <= cnt_r + 2'd1;
        end
        2'b01: begin
          e0_r  <= e1_r;
          cnt_r <= cnt_r - 2'd1;
        end
        2'b11: begin
          // only possible with one word held
          e0_r <= push_item;
        end
        default: begin
          cnt_r <= cnt_r;
        end
      endcase
    end
  end

endmodule

### rtl/core/sspq_back.sv
// sspq_back: sorted cell array and execution sequencer
// depends on sspq_pkg; takes words from sspq_queue
module sspq_back import sspq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int PW    = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  output logic               out_strobe,
  output logic [2:0]         out_status,
  output logic [VALUE_W-1:0] out_value,
  output logic [PRIO_W-1:0]  out_priority,
  output logic [COUNT_W-1:0] out_entry_count,
  output logic               out_last
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [DEPTH-1:0] ONES = '1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPLY,
    S_READ
  } state_t;

  state_t             state_r;
  cmd_t               op_r;
  logic [VALUE_W-1:0] val_r;
  logic [PW-1:0]      prio_r;
  logic [DEPTH-1:0]   mv_r;
  logic [DEPTH-1:0]   pre_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   rd_idx_r;

  logic [VALUE_W-1:0] cell_val_r [DEPTH];
  logic [PW-1:0]      cell_pri_r [DEPTH];

  logic               out_strobe_r;
  status_t            out_status_r;
  logic [VALUE_W-1:0] out_value_r;
  logic [PRIO_W-1:0]  out_priority_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_last_r;

  logic [PW-1:0]      q_pri;
  logic [DEPTH-1:0]   mv_nxt;
  logic [DEPTH-1:0]   match;
  logic [DEPTH-1:0]   pre_nxt;
  logic               is_full;
  logic               found;
  logic               do_ins;
  logic               do_del;
  logic               do_rot;
  logic               rd_last;

  assign q_pri   = q_item.prio[PW-1:0];
  assign q_pop   = (state_r == S_IDLE) & q_valid;
  assign is_full = (count_r == FULL_CNT);
  assign found   = pre_r[DEPTH-1];
  assign do_ins  = (state_r == S_APPLY) & (op_r == CMD_INSERT) & ~is_full;
  assign do_del  = (state_r == S_APPLY) & (op_r == CMD_DELETE) & found;
  assign do_rot  = (state_r == S_READ);
  assign rd_last = ((rd_idx_r + CNT_W'(1)) == count_r);

  // parallel compare of the head word against every live cell
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      mv_nxt[i] = (CNT_W'(i) < count_r) && (cell_pri_r[i] > q_pri);
      match[i]  = (CNT_W'(i) < count_r) && (cell_pri_r[i] == q_pri)
                  && (cell_val_r[i] == q_item.value);
    end
    for (int i = 0; i < DEPTH; i++) begin
      pre_nxt[i] = |(match & (ONES >> (DEPTH - 1 - i)));
    end
  end

  // cell array: shift up on insert, down on delete, rotate on read-out
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    logic [VALUE_W-1:0] ins_val;
    logic [VALUE_W-1:0] dn_val;
    logic [VALUE_W-1:0] rot_val;
    logic [PW-1:0]      ins_pri;
    logic [PW-1:0]      dn_pri;
    logic [PW-1:0]      rot_pri;
    logic               in_use;
    logic               ins_tgt;

    assign in_use  = (CNT_W'(gi) < count_r);
    assign ins_tgt = mv_r[gi] | (CNT_W'(gi) == count_r);

    if (gi == 0) begin : g_head
      assign ins_val = val_r;
      assign ins_pri = prio_r;
    end else begin : g_body
      assign ins_val = mv_r[gi-1] ? cell_val_r[gi-1] : val_r;
      assign ins_pri = mv_r[gi-1] ? cell_pri_r[gi-1] : prio_r;
    end

    if (gi == DEPTH - 1) begin : g_tail
      assign dn_val  = cell_val_r[gi];
      assign dn_pri  = cell_pri_r[gi];
      assign rot_val = cell_val_r[0];
      assign rot_pri = cell_pri_r[0];
    end else begin : g_mid
      assign dn_val  = cell_val_r[gi+1];
      assign dn_pri  = cell_pri_r[gi+1];
      assign rot_val = (CNT_W'(gi + 1) == count_r) ? cell_val_r[0] : cell_val_r[gi+1];
      assign rot_pri = (CNT_W'(gi + 1) == count_r) ? cell_pri_r[0] : cell_pri_r[gi+1];
    end

    always_ff @(posedge clk) begin
      if (do_ins && ins_tgt) begin
        cell_val_r[gi] <= ins_val;
        cell_pri_r[gi] <= ins_pri;
      end else if (do_del && pre_r[gi]) begin
        cell_val_r[gi] <= dn_val;
        cell_pri_r[gi] <= dn_pri;
      end else if (do_rot && in_use) begin
        cell_val_r[gi] <= rot_val;
        cell_pri_r[gi] <= rot_pri;
      end
    end
  end

  // sequencer and registered result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            op_r     <= q_item.op;
            val_r    <= q_item.value;
            prio_r   <= q_pri;
            mv_r     <= mv_nxt;
            pre_r    <= pre_nxt;
            rd_idx_r <= '0;
            if ((q_item.op == CMD_READ) && (count_r != '0)) begin
              state_r <= S_READ;
            end else begin
              state_r <= S_APPLY;
            end
          end
        end
        S_APPLY: begin
          out_strobe_r   <= 1'b1;
          out_last_r     <= 1'b1;
          out_value_r    <= '0;
          out_priority_r <= '0;
          state_r        <= S_IDLE;
          unique case (op_r)
            CMD_INSERT: begin
              if (is_full) begin
                out_status_r <= ST_FULL;
                out_count_r  <= COUNT_W'(count_r);
              end else begin
                out_status_r <= ST_OK;
                count_r      <= count_r + CNT_W'(1);
                out_count_r  <= COUNT_W'(count_r + CNT_W'(1));
              end
            end
            CMD_DELETE: begin
              if (count_r == '0) begin
                out_status_r <= ST_EMPTY_DEL;
                out_count_r  <= '0;
              end else if (!found) begin
                out_status_r <= ST_NOT_FOUND;
                out_count_r  <= COUNT_W'(count_r);
              end else begin
                out_status_r <= ST_OK;
                count_r      <= count_r - CNT_W'(1);
                out_count_r  <= COUNT_W'(count_r - CNT_W'(1));
              end
            end
            default: begin
              // read-out of an empty store
              out_status_r <= ST_EMPTY_RD;
              out_count_r  <= '0;
            end
          endcase
        end
        S_READ: begin
          out_strobe_r   <= 1'b1;
          out_status_r   <= ST_OK;
          out_value_r    <= cell_val_r[0];
          out_priority_r <= PRIO_W'(cell_pri_r[0]);
          out_count_r    <= COUNT_W'(count_r);
          out_last_r     <= rd_last;
          rd_idx_r       <= rd_idx_r + CNT_W'(1);
          if (rd_last) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_status      = out_status_r;
  assign out_value       = out_value_r;
  assign out_priority    = out_priority_r;
  assign out_entry_count = out_count_r;
  assign out_last        = out_last_r;

  // fill level never passes the array size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count beyond depth");

  // an accepted insert grows the store by one
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    do_ins |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the store");

  // read-out runs back to back in ascending priority
  a_read_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && !out_last_r) |=>
      (out_strobe_r && (out_priority_r >= $past(out_priority_r))))
    else $error("read-out not sorted or not contiguous");

endmodule

### rtl/core/stable_sorted_priority_queue_core.sv
// stable_sorted_priority_queue_core: top level of the sorted priority queue
// depends on sspq_pkg, sspq_front, sspq_queue, sspq_back
//
// Holds up to DEPTH entries (32-bit value word, priority) in ascending
// priority order, first-in-first-out among equal priorities.
// Command channel: a word is taken at a rising edge with start high and
// busy low. Commands: insert, delete matching entry, read out all entries;
// code 3 is taken and dropped without a result.
// Result channel: each result word is on the out_ ports for one cycle,
// marked by out_strobe; the receiver cannot stall it, so nothing waits.
// A command word passes through the queue, the sequencer's command
// registers and the registered result word on its way to the out_ ports.
// Insert and delete run a parallel compare over all cells, then a shift;
// read-out gives one result word per stored entry, rotating the cell
// array through cell 0. A two-word queue lets the command side keep
// taking words while a read-out runs; busy is high only when it is full.
// Reset: empties the store at once by clearing the entry count; no
// clearing pass, cell contents are left as they are.
module stable_sorted_priority_queue_core import sspq_pkg::*; #(
  parameter int DEPTH     = 16,
  parameter int PRIO_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic [VALUE_W-1:0] in_item_value,
  input  logic [PRIO_W-1:0]  in_item_priority,
  output logic               out_strobe,
  output logic [2:0]         out_status,
  output logic [VALUE_W-1:0] out_value,
  output logic [PRIO_W-1:0]  out_priority,
  output logic [COUNT_W-1:0] out_entry_count,
  output logic               out_last
);

  // stored priority width: the port carries at most PRIO_W bits
  localparam int PW = (PRIO_BITS < PRIO_W) ? PRIO_BITS : PRIO_W;

  logic  push;
  item_t push_item;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;
  item_t q_head;

  // command intake and decode
  sspq_front #(
    .PW (PW)
  ) u_front (
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .q_full           (q_full),
    .push             (push),
    .push_item        (push_item)
  );

  // decoupling queue
  sspq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .valid     (q_valid),
    .pop       (q_pop),
    .head      (q_head)
  );

  // cell array and execution
  sspq_back #(
    .DEPTH (DEPTH),
    .PW    (PW)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_head),
    .q_pop           (q_pop),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_value       (out_value),
    .out_priority    (out_priority),
    .out_entry_count (out_entry_count),
    .out_last        (out_last)
  );

endmodule

### verif/testbench.sv
// testbench: self-checking bench for stable_sorted_priority_queue_core
// keeps its own sorted store to predict every result word; needs sspq_pkg and the core rtl
// directed cases first, then random insert/delete/read traffic under several idling phases
module testbench import sspq_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH     = 16;
  localparam int PRIO_BITS = 8;
  localparam logic [PRIO_W-1:0] PRIO_MASK = PRIO_W'((1 << PRIO_BITS) - 1);
  // the one command code the block drops without a result
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int TAIL_CYCLES = 2 * DEPTH + 10;

  typedef struct {
    status_t              status;
    logic [VALUE_W-1:0]   value;
    logic [PRIO_W-1:0]    prio;
    logic [COUNT_W-1:0]   count;
    logic                 last;
  } result_word_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_command;
  logic [VALUE_W-1:0] in_item_value;
  logic [PRIO_W-1:0]  in_item_priority;
  logic               out_strobe;
  logic [2:0]         out_status;
  logic [VALUE_W-1:0] out_value;
  logic [PRIO_W-1:0]  out_priority;
  logic [COUNT_W-1:0] out_entry_count;
  logic               out_last;

  // predicted contents of the sorted store
  logic [VALUE_W-1:0] entry_value [DEPTH];
  logic [PRIO_W-1:0]  entry_prio  [DEPTH];
  int                 entry_total;

  result_word_t awaited_words [$];
  int           mismatch_count;
  int           sender_idle_pct;

  stable_sorted_priority_queue_core #(
    .DEPTH     (DEPTH),
    .PRIO_BITS (PRIO_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_value        (out_value),
    .out_priority     (out_priority),
    .out_entry_count  (out_entry_count),
    .out_last         (out_last)
  );

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic void await_word(status_t st, logic [VALUE_W-1:0] val,
                                     logic [PRIO_W-1:0] pri, int cnt, logic lst);
    result_word_t w;
    w.status = st;
    w.value  = val;
    w.prio   = pri;
    w.count  = COUNT_W'(cnt);
    w.last   = lst;
    awaited_words.push_back(w);
  endfunction

  // apply one accepted command to the predicted store and queue its result words
  task automatic update_sorted_store(input logic [1:0] cmd, input logic [VALUE_W-1:0] val,
                                     input logic [PRIO_W-1:0] pri_in);
    logic [PRIO_W-1:0] pri;
    int                pos;
    int                slot;
    bit                found;
    pri   = pri_in & PRIO_MASK;
    found = 1'b0;
    pos   = 0;
    case (cmd)
      CMD_INSERT: begin
        if (entry_total >= DEPTH) begin
          await_word(ST_FULL, '0, '0, entry_total, 1'b1);
        end else begin
          // new entry goes after every entry of equal or lower priority
          while (pos < entry_total && entry_prio[pos] <= pri) pos++;
          for (slot = entry_total; slot > pos; slot--) begin
            entry_value[slot] = entry_value[slot-1];
            entry_prio[slot]  = entry_prio[slot-1];
          end
          entry_value[pos] = val;
          entry_prio[pos]  = pri;
          entry_total++;
          await_word(ST_OK, '0, '0, entry_total, 1'b1);
        end
      end
      CMD_DELETE: begin
        if (entry_total == 0) begin
          await_word(ST_EMPTY_DEL, '0, '0, 0, 1'b1);
        end else begin
          for (slot = 0; slot < entry_total && !found; slot++) begin
            if (entry_prio[slot] == pri && entry_value[slot] == val) begin
              pos   = slot;
              found = 1'b1;
            end
          end
          if (!found) begin
            await_word(ST_NOT_FOUND, '0, '0, entry_total, 1'b1);
          end else begin
            for (slot = pos; slot + 1 < entry_total; slot++) begin
              entry_value[slot] = entry_value[slot+1];
              entry_prio[slot]  = entry_prio[slot+1];
            end
            entry_total--;
            await_word(ST_OK, '0, '0, entry_total, 1'b1);
          end
        end
      end
      CMD_READ: begin
        if (entry_total == 0) begin
          await_word(ST_EMPTY_RD, '0, '0, 0, 1'b1);
        end else begin
          for (slot = 0; slot < entry_total; slot++)
            await_word(ST_OK, entry_value[slot], entry_prio[slot], entry_total,
                       slot + 1 == entry_total);
        end
      end
      default: begin
        // unused code: dropped, nothing changes
      end
    endcase
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatch_count++;
  endtask

  // result checker: every strobed word against the oldest prediction
  always @(posedge clk) begin
    result_word_t w;
    if (rst_n && out_strobe) begin
      if (awaited_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word status %0d value %h prio %0d",
                                  out_status, out_value, out_priority));
      end else begin
        w = awaited_words.pop_front();
        if (out_status !== w.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, w.status));
        if (out_value !== w.value)
          report_mismatch($sformatf("value %h, want %h", out_value, w.value));
        if (out_priority !== w.prio)
          report_mismatch($sformatf("priority %0d, want %0d", out_priority, w.prio));
        if (out_entry_count !== w.count)
          report_mismatch($sformatf("entry count %0d, want %0d", out_entry_count, w.count));
        if (out_last !== w.last)
          report_mismatch($sformatf("last %b, want %b", out_last, w.last));
      end
    end
  end

  // drive one command word from a falling edge, hold it until taken, predict on acceptance
  task automatic send_word(input logic [1:0] cmd, input logic [VALUE_W-1:0] val,
                           input logic [PRIO_W-1:0] pri);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start            = 1'b1;
    in_command       = cmd;
    in_item_value    = val;
    in_item_priority = pri;
    forever begin
      @(posedge clk);
      if (!busy) break;
      @(negedge clk);
    end
    update_sorted_store(cmd, val, pri);
    @(negedge clk);
  endtask

  function automatic logic [PRIO_W-1:0] random_priority();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return PRIO_W'($urandom_range(0, 3));
    if (pick < 55) return (pick < 50) ? '0 : '1;
    return PRIO_W'($urandom);
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) return VALUE_W'($urandom_range(0, 3));
    if (pick < 30) return (pick < 25) ? '0 : '1;
    return $urandom;
  endfunction

  // empty store: read, delete and the dropped code
  task automatic test_empty_store();
    send_word(CMD_READ, '0, '0);
    send_word(CMD_DELETE, 32'hdead_beef, 8'h12);
    send_word(CMD_UNUSED, '1, '1);
  endtask

  // extremes, ties kept in arrival order, raw-bit matching on delete
  task automatic test_ordering_and_delete();
    send_word(CMD_INSERT, '1, '1);
    send_word(CMD_INSERT, '0, '0);
    send_word(CMD_INSERT, 32'h0000_00aa, 8'd5);
    send_word(CMD_INSERT, 32'h8000_0001, 8'd5);
    send_word(CMD_INSERT, 32'h0000_00aa, 8'd5);
    send_word(CMD_READ, '0, '0);
    send_word(CMD_DELETE, 32'h0000_00aa, 8'd6);
    send_word(CMD_DELETE, 32'h0000_00ab, 8'd5);
    send_word(CMD_DELETE, 32'h0000_00aa, 8'd5);
    send_word(CMD_READ, '0, '0);
  endtask

  // fill to the limit, then one insert too many
  task automatic test_full_store();
    while (entry_total < DEPTH)
      send_word(CMD_INSERT, $urandom, PRIO_W'($urandom_range(0, 2)) << (2 * entry_total % 8));
    send_word(CMD_INSERT, 32'h5a5a_a5a5, 8'd1);
    send_word(CMD_READ, '0, '0);
  endtask

  // random traffic swinging between filling and draining the store
  task automatic test_random_traffic(input int word_total, input int idle_pct);
    int                 sent;
    int                 pick;
    int                 slot;
    bit                 filling;
    logic [VALUE_W-1:0] val;
    logic [PRIO_W-1:0]  pri;
    sender_idle_pct = idle_pct;
    sent            = 0;
    filling         = 1'b1;
    while (sent < word_total) begin
      if (entry_total == DEPTH) filling = 1'b0;
      else if (entry_total == 0) filling = 1'b1;
      else if ($urandom_range(0, 99) < 4) filling = !filling;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send_word(CMD_UNUSED, $urandom, PRIO_W'($urandom));
      end else if (pick < 18) begin
        send_word(CMD_READ, $urandom, PRIO_W'($urandom));
        sent++;
      end else if ((pick < 62) == filling) begin
        // insert, sometimes repeating a stored value word
        val = random_value();
        if (entry_total > 0 && $urandom_range(0, 99) < 25)
          val = entry_value[$urandom_range(0, entry_total - 1)];
        send_word(CMD_INSERT, val, random_priority());
        sent++;
      end else begin
        // delete, mostly of a stored entry, else a near miss or noise
        val = random_value();
        pri = random_priority();
        if (entry_total > 0 && $urandom_range(0, 99) < 85) begin
          slot = $urandom_range(0, entry_total - 1);
          val  = entry_value[slot];
          pri  = entry_prio[slot];
          if ($urandom_range(0, 99) < 10) pri = pri ^ PRIO_W'(1 << $urandom_range(0, 7));
          else if ($urandom_range(0, 99) < 10) val = val ^ (32'd1 << $urandom_range(0, 31));
        end
        send_word(CMD_DELETE, val, pri);
        sent++;
      end
    end
  endtask

  // run-time limit
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // main sequence
  initial begin
    rst_n            = 1'b0;
    start            = 1'b0;
    in_command       = CMD_INSERT;
    in_item_value    = '0;
    in_item_priority = '0;
    entry_total      = 0;
    mismatch_count   = 0;
    sender_idle_pct  = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_store();
    test_ordering_and_delete();
    test_full_store();
    test_random_traffic(105, 0);
    test_random_traffic(105, 74);
    test_random_traffic(105, 29);
    test_random_traffic(105, 0);

    start = 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
